/* rtl/block_mean_color_nearest_match_defines.svh */
// assertion macros shared by the tile matcher rtl
`ifndef BLOCK_MEAN_COLOR_NEAREST_MATCH_DEFINES_SVH
`define BLOCK_MEAN_COLOR_NEAREST_MATCH_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bmc_pkg.sv */
// shared types and constants of the tile matcher
`timescale 1ns / 1ps
`default_nettype none
package bmc_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 20;
  localparam int unsigned SQ_W        = 2 * SUM_W;
  localparam int unsigned DIST_W      = SQ_W + 2;
  localparam int unsigned TILE_W      = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_TILE    = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  // finished block handed from front to back
  typedef struct packed {
    logic             op;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
  } cmd_t;

  typedef struct packed {
    logic [TILE_W-1:0] best_tile;
    logic              table_empty;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_DRAIN,
    BK_REPORT
  } back_state_e;

endpackage
`default_nettype wire

/* rtl/bmc_fifo.sv */
// small first-in first-out queue
`timescale 1ns / 1ps
`default_nettype none
`include "block_mean_color_nearest_match_defines.svh"
module bmc_fifo #(
  parameter int unsigned DataW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [DataW-1:0] data_o,
  output logic                  empty_o
);
  import bmc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [DataW-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `BMC_ASSERT_IMP(a_fifo_cnt_bound, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH), "fifo count overflow")
  `BMC_ASSERT_NXT(a_fifo_pop_dec, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1, "fifo pop lost")

endmodule
`default_nettype wire

/* rtl/bmc_front.sv */
// pixel intake: saturating channel sums, block end hand-off
`timescale 1ns / 1ps
`default_nettype none
module bmc_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  output logic                           full_o,
  input  wire logic                      opcode_i,
  input  wire logic [bmc_pkg::PIX_W-1:0] pixel_blue_i,
  input  wire logic [bmc_pkg::PIX_W-1:0] pixel_green_i,
  input  wire logic [bmc_pkg::PIX_W-1:0] pixel_red_i,
  input  wire logic                      last_pixel_i,
  input  wire logic                      cmd_full_i,
  output logic                           cmd_push_o,
  output bmc_pkg::cmd_t                  cmd_o
);
  import bmc_pkg::*;

  logic [SUM_W-1:0] sum_b_q, sum_g_q, sum_r_q;
  logic [SUM_W-1:0] sum_b_d, sum_g_d, sum_r_d;
  logic             accept;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [PIX_W-1:0] pix);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - PIX_W){1'b0}}, pix};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  assign full_o     = cmd_full_i;
  assign accept     = push_i & ~cmd_full_i;
  assign cmd_push_o = accept & last_pixel_i;

  assign sum_b_d = sat_add(sum_b_q, pixel_blue_i);
  assign sum_g_d = sat_add(sum_g_q, pixel_green_i);
  assign sum_r_d = sat_add(sum_r_q, pixel_red_i);

  assign cmd_o.op    = opcode_i;
  assign cmd_o.sum_b = sum_b_d;
  assign cmd_o.sum_g = sum_g_d;
  assign cmd_o.sum_r = sum_r_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_b_q <= '0;
      sum_g_q <= '0;
      sum_r_q <= '0;
    end else if (accept) begin
      if (last_pixel_i) begin
        sum_b_q <= '0;
        sum_g_q <= '0;
        sum_r_q <= '0;
      end else begin
        sum_b_q <= sum_b_d;
        sum_g_q <= sum_g_d;
        sum_r_q <= sum_r_d;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bmc_back.sv */
// block execution: tile table store and nearest-tile search pipeline
`timescale 1ns / 1ps
`default_nettype none
`include "block_mean_color_nearest_match_defines.svh"
module bmc_back #(
  parameter int unsigned MAX_TILES = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire bmc_pkg::cmd_t cmd_i,
  input  wire logic   cmd_empty_i,
  output logic        cmd_pop_o,
  input  wire logic   res_full_i,
  output logic        res_push_o,
  output bmc_pkg::res_t res_o
);
  import bmc_pkg::*;

  localparam int unsigned IdxW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned CntW = $clog2(MAX_TILES + 1);

  back_state_e state_q, state_d;

  logic [3*SUM_W-1:0] tbl_q [MAX_TILES];
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    addr_q, addr_d;
  logic [SUM_W-1:0]   seg_b_q, seg_g_q, seg_r_q;

  logic               wr_en, rd_en, seg_start;

  // search pipeline
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [IdxW-1:0]    idx1_q, idx2_q, idx3_q, idx4_q;
  logic [3*SUM_W-1:0] rd_data_q;
  logic [SUM_W-1:0]   dif_b_q, dif_g_q, dif_r_q;
  logic [SQ_W-1:0]    sq_b_q, sq_g_q, sq_r_q;
  logic [DIST_W-1:0]  dist_q;
  logic [DIST_W-1:0]  best_dist_q;
  logic [IdxW-1:0]    best_idx_q;
  logic               found_q;
  logic [IdxW+TILE_W-1:0] best_ext;

  function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign cmd_pop_o = (state_q == BK_IDLE) && !cmd_empty_i;
  assign wr_en     = cmd_pop_o && (cmd_i.op == OP_TILE) && (cnt_q < CntW'(MAX_TILES));
  assign seg_start = cmd_pop_o && (cmd_i.op == OP_SEGMENT);
  assign rd_en     = (state_q == BK_SEARCH);

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    res_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        addr_d = '0;
        if (seg_start) begin
          state_d = (cnt_q == '0) ? BK_REPORT : BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        addr_d = addr_q + 1'b1;
        if (addr_d == cnt_q) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!(v1_q || v2_q || v3_q || v4_q)) begin
          state_d = BK_REPORT;
        end
      end
      BK_REPORT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign best_ext          = {{TILE_W{1'b0}}, best_idx_q};
  assign res_o.best_tile   = best_ext[TILE_W-1:0];
  assign res_o.table_empty = ~found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      addr_q  <= '0;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      v1_q    <= rd_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      if (wr_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (seg_start) begin
        found_q <= 1'b0;
      end else if (v4_q) begin
        found_q <= 1'b1;
      end
    end
  end

  // table port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[cnt_q[IdxW-1:0]] <= {cmd_i.sum_r, cmd_i.sum_g, cmd_i.sum_b};
    end
    if (rd_en) begin
      rd_data_q <= tbl_q[addr_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_start) begin
      seg_b_q <= cmd_i.sum_b;
      seg_g_q <= cmd_i.sum_g;
      seg_r_q <= cmd_i.sum_r;
    end
    idx1_q  <= addr_q[IdxW-1:0];
    idx2_q  <= idx1_q;
    dif_b_q <= abs_diff(seg_b_q, rd_data_q[SUM_W-1:0]);
    dif_g_q <= abs_diff(seg_g_q, rd_data_q[2*SUM_W-1:SUM_W]);
    dif_r_q <= abs_diff(seg_r_q, rd_data_q[3*SUM_W-1:2*SUM_W]);
    idx3_q  <= idx2_q;
    sq_b_q  <= dif_b_q * dif_b_q;
    sq_g_q  <= dif_g_q * dif_g_q;
    sq_r_q  <= dif_r_q * dif_r_q;
    idx4_q  <= idx3_q;
    dist_q  <= {2'b00, sq_b_q} + {2'b00, sq_g_q} + {2'b00, sq_r_q};
    if (seg_start) begin
      best_idx_q <= '0;
    end else if (v4_q && (!found_q || dist_q < best_dist_q)) begin
      best_idx_q  <= idx4_q;
      best_dist_q <= dist_q;
    end
  end

  `BMC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(MAX_TILES), "tile count above capacity")
  `BMC_ASSERT_IMP(a_rd_in_range, state_q == BK_SEARCH, addr_q < cnt_q, "search past stored tiles")

endmodule
`default_nettype wire

/* rtl/block_mean_color_nearest_match.sv */
// a tile block reaches the table through the block queue; a segment result follows a walk
// over the stored tiles and the search pipeline, or skips both when the table is empty
// throughput: one pixel per cycle; input stalls only while the block queue is full, the
// back end walks a segment's tiles through the single table read port, popping no block meanwhile
// reset: asynchronous, active low; clears sums, tile count, queues and search control,
// the tile table itself is not cleared and is only read below the tile count
`timescale 1ns / 1ps
`default_nettype none
module block_mean_color_nearest_match #(
  parameter int unsigned MAX_TILES = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // pixel requests
  input  wire logic       push,
  output logic            full,
  input  wire logic       opcode_i,
  input  wire logic [7:0] pixel_blue_i,
  input  wire logic [7:0] pixel_green_i,
  input  wire logic [7:0] pixel_red_i,
  input  wire logic       last_pixel_i,
  // match results
  output logic            empty,
  input  wire logic       pop,
  output logic      [9:0] best_tile_o,
  output logic            table_empty_o
);
  import bmc_pkg::*;

  // front to back: finished block sums
  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  // back to output queue
  res_t res_in, res_out;
  logic res_push, res_full;

  // front end: accumulates channel sums, hands each block end to the queue
  bmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .pixel_blue_i (pixel_blue_i),
    .pixel_green_i(pixel_green_i),
    .pixel_red_i  (pixel_red_i),
    .last_pixel_i (last_pixel_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // short block queue so pixels keep flowing during a search
  bmc_fifo #(
    .DataW($bits(cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // back end: stores tiles, walks the table for each segment
  bmc_back #(
    .MAX_TILES(MAX_TILES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue doubles as the output register
  bmc_fifo #(
    .DataW($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign best_tile_o   = res_out.best_tile;
  assign table_empty_o = res_out.table_empty;

endmodule
`default_nettype wire

/* bench/bmc_match_checker.sv */
// watches the pixel and result channels of the tile matcher, predicts each match and compares
`timescale 1ns / 1ps
module bmc_match_checker #(
  parameter int unsigned MAX_TILES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic                         opcode_i,
  input  logic [bmc_pkg::PIX_W-1:0]    pixel_blue_i,
  input  logic [bmc_pkg::PIX_W-1:0]    pixel_green_i,
  input  logic [bmc_pkg::PIX_W-1:0]    pixel_red_i,
  input  logic                         last_pixel_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [bmc_pkg::TILE_W-1:0]   best_tile_i,
  input  logic                         table_empty_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import bmc_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } color_sums_t;

  color_sums_t tile_sums [MAX_TILES];
  int unsigned tiles_held;
  color_sums_t block_sums;
  res_t        match_q [$];

  function automatic logic [SUM_W-1:0] sat_accumulate(logic [SUM_W-1:0] acc,
                                                      logic [PIX_W-1:0] pix);
    logic [SUM_W:0] total;
    total = acc + pix;
    return total[SUM_W] ? '1 : total[SUM_W-1:0];
  endfunction

  function automatic longint unsigned channel_sq(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    longint unsigned gap;
    gap = (a > b) ? 64'(a - b) : 64'(b - a);
    return gap * gap;
  endfunction

  // lowest index wins on equal distance
  function automatic res_t nearest_tile(color_sums_t seg);
    res_t            found;
    longint unsigned span;
    longint unsigned best_span;
    int unsigned     idx;
    found.best_tile   = '0;
    found.table_empty = 1'b1;
    best_span         = '0;
    for (idx = 0; idx < tiles_held; idx++) begin
      span = channel_sq(seg.blue, tile_sums[idx].blue)
           + channel_sq(seg.green, tile_sums[idx].green)
           + channel_sq(seg.red, tile_sums[idx].red);
      if (found.table_empty || span < best_span) begin
        found.table_empty = 1'b0;
        found.best_tile   = TILE_W'(idx);
        best_span         = span;
      end
    end
    return found;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    color_sums_t next_sums;
    res_t        want;
    if (!rst_ni) begin
      tiles_held = 0;
      block_sums = '0;
      match_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (match_q.size() == 0) begin
          fail_count_o++;
          $display(
            "%0t: unexpected result, expected none actual best_tile=%0d table_empty=%0b",
            $time, best_tile_i, table_empty_i);
        end else begin
          want = match_q.pop_front();
          if (best_tile_i !== want.best_tile) begin
            fail_count_o++;
            $display("%0t: best_tile expected %0d actual %0d",
                     $time, want.best_tile, best_tile_i);
          end
          if (table_empty_i !== want.table_empty) begin
            fail_count_o++;
            $display("%0t: table_empty expected %0b actual %0b",
                     $time, want.table_empty, table_empty_i);
          end
        end
      end
      if (push_i && !full_i) begin
        next_sums.blue  = sat_accumulate(block_sums.blue, pixel_blue_i);
        next_sums.green = sat_accumulate(block_sums.green, pixel_green_i);
        next_sums.red   = sat_accumulate(block_sums.red, pixel_red_i);
        if (!last_pixel_i) begin
          block_sums = next_sums;
        end else begin
          block_sums = '0;
          if (opcode_i == OP_SEGMENT) begin
            match_q = {match_q, nearest_tile(next_sums)};
          end else if (tiles_held < MAX_TILES) begin
            tile_sums[tiles_held] = next_sums;
            tiles_held++;
          end
        end
      end
    end
    pending_o = match_q.size();
  end

endmodule

/* bench/block_mean_color_nearest_match_tb.sv */
// stimulus and verdict for the mean-color nearest tile matcher
`timescale 1ns / 1ps
module block_mean_color_nearest_match_tb;
  import bmc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned MAX_TILES     = 1024;
  // random pixel requests, split over the three idling phases
  localparam int unsigned RANDOM_PIXELS = 870;
  // a segment search walks the whole table, so allow a full table plus pipeline
  localparam int unsigned DRAIN_CYCLES  = MAX_TILES + 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        opcode_i;
  logic [7:0]  pixel_blue_i;
  logic [7:0]  pixel_green_i;
  logic [7:0]  pixel_red_i;
  logic        last_pixel_i;
  logic        empty;
  logic        pop;
  logic [9:0]  best_tile_o;
  logic        table_empty_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pending;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  block_mean_color_nearest_match #(
    .MAX_TILES(MAX_TILES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .pixel_blue_i (pixel_blue_i),
    .pixel_green_i(pixel_green_i),
    .pixel_red_i  (pixel_red_i),
    .last_pixel_i (last_pixel_i),
    .empty        (empty),
    .pop          (pop),
    .best_tile_o  (best_tile_o),
    .table_empty_o(table_empty_o)
  );

  // the checker sees every handshake on both sides and keeps its own tile table
  bmc_match_checker #(
    .MAX_TILES(MAX_TILES)
  ) match_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .opcode_i     (opcode_i),
    .pixel_blue_i (pixel_blue_i),
    .pixel_green_i(pixel_green_i),
    .pixel_red_i  (pixel_red_i),
    .last_pixel_i (last_pixel_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .best_tile_i  (best_tile_o),
    .table_empty_i(table_empty_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: pop is redrawn every falling edge, held low during reset
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one pixel request: random idle cycles first, then hold it until full is low at an edge
  task automatic send_pixel(input logic op, input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red, input logic last_pix);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    push          <= 1'b1;
    opcode_i      <= op;
    pixel_blue_i  <= blue;
    pixel_green_i <= green;
    pixel_red_i   <= red;
    last_pixel_i  <= last_pix;
    do @(posedge clk_i); while (full);
  endtask

  // block of one uniform color, last flag on the final pixel
  task automatic send_block(input logic op, input int unsigned len, input logic [7:0] blue,
                            input logic [7:0] green, input logic [7:0] red);
    int unsigned idx;
    for (idx = 1; idx <= len; idx++)
      send_pixel(op, blue, green, red, idx == len);
  endtask

  // extremes are favored so short blocks often land on equal sums and force ties
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // well-formed blocks with random content; a stray opcode now and then makes mixed blocks
  task automatic random_blocks(input int unsigned pixel_budget);
    int unsigned sent;
    int unsigned len;
    int unsigned idx;
    logic        op;
    logic        pix_op;
    sent = 0;
    while (sent < pixel_budget) begin
      op  = 1'($urandom_range(1));
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 4);
      for (idx = 1; idx <= len; idx++) begin
        pix_op = ($urandom_range(7) == 0) ? ~op : op;
        send_pixel(pix_op, rand_channel(), rand_channel(), rand_channel(), idx == len);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    opcode_i      = OP_TILE;
    pixel_blue_i  = '0;
    pixel_green_i = '0;
    pixel_red_i   = '0;
    last_pixel_i  = 1'b0;
    cycle_count   = 0;
    // first phase: sender idles lightly, receiver heavily
    send_idle_pct = 23;
    recv_idle_pct = 51;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // segments against an empty table, single pixel and multi-pixel
    send_pixel(OP_SEGMENT, 8'h00, 8'h00, 8'h00, 1'b1);
    send_block(OP_SEGMENT, 2, 8'hFF, 8'hFF, 8'hFF);
    // tiles 0..2: black, white, black again
    send_block(OP_TILE, 1, 8'h00, 8'h00, 8'h00);
    send_block(OP_TILE, 1, 8'hFF, 8'hFF, 8'hFF);
    send_block(OP_TILE, 1, 8'h00, 8'h00, 8'h00);
    // black segment ties tiles 0 and 2, the lower index must win
    send_block(OP_SEGMENT, 1, 8'h00, 8'h00, 8'h00);
    // mid grey sits just nearer to white
    send_block(OP_SEGMENT, 1, 8'h80, 8'h80, 8'h80);
    // mixed blocks: only the opcode on the last pixel counts
    send_pixel(OP_SEGMENT, 8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(OP_TILE, 8'd4, 8'd5, 8'd6, 1'b1);
    send_pixel(OP_TILE, 8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(OP_SEGMENT, 8'h00, 8'h00, 8'h00, 1'b1);
    send_block(OP_SEGMENT, 2, 8'd3, 8'd4, 8'd5);
    // alternating bit patterns on every channel
    send_pixel(OP_SEGMENT, 8'hAA, 8'h55, 8'hAA, 1'b0);
    send_pixel(OP_SEGMENT, 8'h55, 8'hAA, 8'h55, 1'b1);

    random_blocks(RANDOM_PIXELS / 3);
    // second phase: the other way round
    send_idle_pct = 51;
    recv_idle_pct = 23;
    random_blocks(RANDOM_PIXELS / 3);
    // third phase: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_blocks(RANDOM_PIXELS / 3);

    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // catch any result that shows up with nothing waiting for it
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
